FILE: rtl/strided_tensor_gather_address_assert.svh
// assertion macros for the strided tensor gather address generator
// no dependencies; included by the top level
`ifndef STRIDED_TENSOR_GATHER_ADDRESS_ASSERT_SVH
`define STRIDED_TENSOR_GATHER_ADDRESS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define STGA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stga assertion failed");

// next-cycle implication, checked outside reset
`define STGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stga assertion failed");

`endif

FILE: rtl/stga_pkg.sv
// shared types and constants for the strided tensor gather address generator
// no dependencies
package stga_pkg;

    localparam int OFFSET_W     = 48;
    localparam int STRIDE_W     = 32;
    localparam int EXT_FIELD_W  = 16;
    localparam int GEOM_W       = 48;
    localparam int ELEM_BYTES_W = 5;
    localparam int DIM_COUNT_W  = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int NUM_GEOM     = 4;

    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_EXTENT_BITS = 16;

    localparam logic [ELEM_BYTES_W-1:0] ELEM_BYTES_RST = 5'd4;
    localparam logic [DIM_COUNT_W-1:0]  DIM_COUNT_RST  = 3'd1;
    localparam logic [GEOM_W-1:0]       GEOM_RST       = 48'd1;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEM_BYTES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM0_GEOM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM1_GEOM  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM2_GEOM  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM3_GEOM  = 3'd5;

    typedef struct packed {
        logic [ELEM_BYTES_W-1:0]                   elem_bytes;
        logic [DIM_COUNT_W-1:0]                    used_dims;
        logic [NUM_GEOM-1:0][EXT_FIELD_W-1:0]      extent;
        logic [NUM_GEOM-1:0][STRIDE_W-1:0]         stride;
    } cfg_t;

    // first pipeline stage status handed from the counter to the offset pipe
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [OFFSET_W-1:0] count;
    } stage_t;

endpackage

FILE: rtl/stga_cfg_regs.sv
// configuration registers of the strided tensor gather address generator
// depends on stga_pkg
module stga_cfg_regs
    import stga_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GEOM_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    localparam logic [DIM_COUNT_W-1:0] DIM_LIMIT = DIM_COUNT_W'(MAX_DIMS);

    logic [ELEM_BYTES_W-1:0]         elem_bytes_reg, elem_bytes_next;
    logic [DIM_COUNT_W-1:0]          dim_count_reg, dim_count_next;
    logic [NUM_GEOM-1:0][GEOM_W-1:0] geom_reg, geom_next;

    always_comb
    begin
        elem_bytes_next = elem_bytes_reg;
        dim_count_next  = dim_count_reg;
        geom_next       = geom_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ELEM_BYTES: elem_bytes_next = cfg_data[ELEM_BYTES_W-1:0];
                CFG_DIM_COUNT:  dim_count_next  = cfg_data[DIM_COUNT_W-1:0];
                CFG_DIM0_GEOM:  geom_next[0]    = cfg_data;
                CFG_DIM1_GEOM:  geom_next[1]    = cfg_data;
                CFG_DIM2_GEOM:  geom_next[2]    = cfg_data;
                CFG_DIM3_GEOM:  geom_next[3]    = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_bytes_reg <= ELEM_BYTES_RST;
            dim_count_reg  <= DIM_COUNT_RST;
            for (int d = 0; d < NUM_GEOM; d++)
            begin
                geom_reg[d] <= GEOM_RST;
            end
        end
        else
        begin
            elem_bytes_reg <= elem_bytes_next;
            dim_count_reg  <= dim_count_next;
            geom_reg       <= geom_next;
        end
    end

    always_comb
    begin
        cfg.elem_bytes = elem_bytes_reg;
        cfg.used_dims  = (dim_count_reg > DIM_LIMIT) ? DIM_LIMIT : dim_count_reg;
        for (int d = 0; d < NUM_GEOM; d++)
        begin
            cfg.extent[d] = geom_reg[d][EXT_FIELD_W-1:0];
            cfg.stride[d] = geom_reg[d][EXT_FIELD_W +: STRIDE_W];
        end
    end

endmodule

FILE: rtl/stga_index_counter.sv
// per-dimension index counters and element count, first pipeline stage
// depends on stga_pkg
module stga_index_counter
    import stga_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS,
    localparam int IDX_W = (EXTENT_BITS < EXT_FIELD_W) ? EXTENT_BITS : EXT_FIELD_W
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    input  logic                          pipe_ready,
    output stage_t                        s1,
    output logic [MAX_DIMS-1:0][IDX_W-1:0] s1_idx
);

    logic [MAX_DIMS-1:0][IDX_W-1:0] idx_reg, idx_next;
    logic [OFFSET_W-1:0]            count_reg, count_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_last_reg, s1_last_next;
    logic [OFFSET_W-1:0]            s1_count_reg, s1_count_next;
    logic [MAX_DIMS-1:0][IDX_W-1:0] s1_idx_reg, s1_idx_next;

    logic [MAX_DIMS-1:0][IDX_W-1:0] idx_cur;
    logic [MAX_DIMS-1:0][IDX_W-1:0] ext;
    logic [MAX_DIMS-1:0][IDX_W:0]   nx;
    logic [OFFSET_W-1:0]            count_cur;
    logic                           last;
    logic                           carry;
    logic                           s1_ready;
    logic                           accept;

    assign s1_ready = !s1_valid_reg || pipe_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    always_comb
    begin
        count_cur = restart ? '0 : count_reg;
        last      = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            idx_cur[d] = restart ? '0 : idx_reg[d];
            ext[d]     = cfg.extent[d][IDX_W-1:0];
            if (ext[d] == '0)
            begin
                ext[d] = IDX_W'(1);
            end
            nx[d] = {1'b0, idx_cur[d]} + (IDX_W+1)'(1);
            if ((DIM_COUNT_W'(d) < cfg.used_dims) && (nx[d] < {1'b0, ext[d]}))
            begin
                last = 1'b0;
            end
        end
    end

    always_comb
    begin
        idx_next      = idx_reg;
        count_next    = count_reg;
        s1_idx_next   = s1_idx_reg;
        s1_count_next = s1_count_reg;
        s1_last_next  = s1_last_reg;
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        carry         = 1'b1;
        if (accept)
        begin
            s1_count_next = count_cur;
            s1_last_next  = last;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                s1_idx_next[d] = (DIM_COUNT_W'(d) < cfg.used_dims) ? idx_cur[d] : '0;
            end
            if (last)
            begin
                idx_next   = '0;
                count_next = '0;
            end
            else
            begin
                idx_next = idx_cur;
                // fastest dimension is the highest used one, carry ripples down
                for (int d = MAX_DIMS - 1; d >= 0; d--)
                begin
                    if ((DIM_COUNT_W'(d) < cfg.used_dims) && carry)
                    begin
                        if (nx[d] < {1'b0, ext[d]})
                        begin
                            idx_next[d] = nx[d][IDX_W-1:0];
                            carry       = 1'b0;
                        end
                        else
                        begin
                            idx_next[d] = '0;
                        end
                    end
                end
                count_next = count_cur + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s1_count_reg <= s1_count_next;
        s1_last_reg  <= s1_last_next;
    end

    always_comb
    begin
        s1.valid = s1_valid_reg;
        s1.last  = s1_last_reg;
        s1.count = s1_count_reg;
    end
    assign s1_idx = s1_idx_reg;

endmodule

FILE: rtl/stga_offset_pipe.sv
// offset multiply and sum stages with the output register
// depends on stga_pkg
module stga_offset_pipe
    import stga_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS,
    localparam int IDX_W = (EXTENT_BITS < EXT_FIELD_W) ? EXTENT_BITS : EXT_FIELD_W
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  stage_t                         s1,
    input  logic [MAX_DIMS-1:0][IDX_W-1:0] s1_idx,
    output logic                           pipe_ready,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [OFFSET_W-1:0]            src_offset,
    output logic [OFFSET_W-1:0]            dst_offset_bytes,
    output logic                           last_element
);

    localparam int PROD_W  = IDX_W + STRIDE_W;
    localparam int SCALE_W = OFFSET_W + ELEM_BYTES_W;

    logic v2_reg, v3_reg, v4_reg;
    logic ready2, ready3, ready4;

    logic [MAX_DIMS-1:0][OFFSET_W-1:0] prod_reg, prod_next;
    logic [OFFSET_W-1:0]               dst2_reg, dst2_next;
    logic                              last2_reg;
    logic [MAX_DIMS-1:0][OFFSET_W-1:0] term_reg, term_next;
    logic [OFFSET_W-1:0]               dst3_reg;
    logic                              last3_reg;
    logic [OFFSET_W-1:0]               src_reg, src_next;
    logic [OFFSET_W-1:0]               dst4_reg;
    logic                              last4_reg;

    logic [MAX_DIMS-1:0][PROD_W-1:0]   prod_full;
    logic [MAX_DIMS-1:0][SCALE_W-1:0]  term_full;
    logic [SCALE_W-1:0]                dst_full;

    assign ready4     = !v4_reg || !out_stall;
    assign ready3     = !v3_reg || ready4;
    assign ready2     = !v2_reg || ready3;
    assign pipe_ready = ready2;

    // index times stride, and element count times element size
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            prod_full[d] = s1_idx[d] * cfg.stride[d];
            prod_next[d] = OFFSET_W'(prod_full[d]);
        end
        dst_full  = s1.count * cfg.elem_bytes;
        dst2_next = dst_full[OFFSET_W-1:0];
    end

    // scale each lane by the element size
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            term_full[d] = prod_reg[d] * cfg.elem_bytes;
            term_next[d] = term_full[d][OFFSET_W-1:0];
        end
    end

    always_comb
    begin
        src_next = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            src_next = src_next + term_reg[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= s1.valid;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            prod_reg  <= prod_next;
            dst2_reg  <= dst2_next;
            last2_reg <= s1.last;
        end
        if (ready3)
        begin
            term_reg  <= term_next;
            dst3_reg  <= dst2_reg;
            last3_reg <= last2_reg;
        end
        if (ready4)
        begin
            src_reg   <= src_next;
            dst4_reg  <= dst3_reg;
            last4_reg <= last3_reg;
        end
    end

    assign out_valid        = v4_reg;
    assign src_offset       = src_reg;
    assign dst_offset_bytes = dst4_reg;
    assign last_element     = last4_reg;

endmodule

FILE: rtl/strided_tensor_gather_address.sv
// top level of the strided tensor gather address generator
// depends on stga_pkg, stga_cfg_regs, stga_index_counter, stga_offset_pipe
// and strided_tensor_gather_address_assert.svh
//
// usage
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//     always high, so a write lands at every edge with cfg_valid high. indexes 0..5
//     select elem_bytes, dim_count and the four geometry registers, others drop.
//     write only while no transaction is in flight.
//   input channel: one transaction per element request (in_valid/in_stall), restart
//     clears the index counters before that element's offsets are formed
//   output channel: one transaction per request (out_valid/out_stall) carrying the
//     source and destination byte offsets and the last-element flag
//   pipeline: an input transaction passes four registers (counter stage, index times
//     stride, scale by element size, lane sum into the output register) before
//     out_valid rises
//   throughput: one element per cycle while out_stall is low; the index counter
//     update is the only loop and closes through the counter registers
//   stall: a stalled output holds its register; the three stages behind it keep
//     filling, and in_stall rises only when all four stages hold an element
//   reset: counters cleared, config back to elem_bytes 4, dim_count 1, geometry 1,
//     pipeline empty
`include "strided_tensor_gather_address_assert.svh"

module strided_tensor_gather_address
    import stga_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GEOM_W-1:0]      cfg_data,
    // element request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    // offset result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OFFSET_W-1:0]    src_offset,
    output logic [OFFSET_W-1:0]    dst_offset_bytes,
    output logic                   last_element
);

    // index width follows the extent width, never above the 16-bit extent field
    localparam int IDX_W = (EXTENT_BITS < EXT_FIELD_W) ? EXTENT_BITS : EXT_FIELD_W;

    cfg_t                           cfg;
    stage_t                         s1;
    logic [MAX_DIMS-1:0][IDX_W-1:0] s1_idx;
    logic                           pipe_ready;
    logic                           in_accept;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;

    stga_cfg_regs #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // counter stage: forms this element's indices and advances to the next one
    stga_index_counter #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_index_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .pipe_ready (pipe_ready),
        .s1         (s1),
        .s1_idx     (s1_idx)
    );

    // multiply, scale and sum stages ending in the output register
    stga_offset_pipe #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_offset_pipe (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .s1               (s1),
        .s1_idx           (s1_idx),
        .pipe_ready       (pipe_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .src_offset       (src_offset),
        .dst_offset_bytes (dst_offset_bytes),
        .last_element     (last_element)
    );

    // input backpressure only when every stage is occupied and the output is held
    `STGA_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall)
    // an accepted request always lands in the counter stage
    `STGA_ASSERT_NEXT(a_accept_s1, clk, rst_n, in_accept, s1.valid)
    // restart starts the destination count from zero
    `STGA_ASSERT_NEXT(a_restart_count, clk, rst_n, in_accept && restart, s1.count == '0)

endmodule

FILE: bench/strided_tensor_gather_address_test.sv
`timescale 1ns / 100ps
// self-checking bench for the strided tensor gather address generator
// depends on stga_pkg and the strided_tensor_gather_address top level
module strided_tensor_gather_address_test;
    import stga_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    // four register stages between a request and its offsets
    localparam int PIPE_DEPTH   = 4;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_GOAL  = 1050;
    localparam int DEEP_WALK    = 400;
    localparam int REPORT_MAX   = 10;

    // indexes the block decodes to nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    // traffic shaping per phase
    typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] src;
        logic [OFFSET_W-1:0] dst;
        logic                last;
    } offset_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [GEOM_W-1:0]      cfg_data = '0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   restart = 1'b0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [OFFSET_W-1:0]    src_offset;
    logic [OFFSET_W-1:0]    dst_offset_bytes;
    logic                   last_element;

    // stimulus and expectation stores
    bit          pending_restart[$];
    offset_rec_t expected_offsets[$];

    // shaping knobs; the sequencer writes the percentages and hold_asked, the hold counter the rest
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    // run statistics
    int fail_count = 0;
    int requests_sent = 0;
    int restarts_sent = 0;
    int lasts_seen = 0;
    int setups = 0;
    int input_stalls = 0;

    // mirror of the block's registers and walk state
    logic [ELEM_BYTES_W-1:0]            geo_elem_bytes = ELEM_BYTES_RST;
    logic [DIM_COUNT_W-1:0]             geo_dim_count = DIM_COUNT_RST;
    logic [GEOM_W-1:0]                  geo_shape[NUM_GEOM] = '{default: GEOM_RST};
    logic [EXT_FIELD_W-1:0]             walk_index[NUM_GEOM] = '{default: '0};
    logic [OFFSET_W-1:0]                element_total = '0;

    strided_tensor_gather_address #(
        .MAX_DIMS    (DEF_MAX_DIMS),
        .EXTENT_BITS (DEF_EXTENT_BITS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .restart          (restart),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .src_offset       (src_offset),
        .dst_offset_bytes (dst_offset_bytes),
        .last_element     (last_element)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // offset predictor
    // ------------------------------------------------------------------

    // zero extent behaves as a single position
    function automatic int unsigned extent_of(input int k);
        int unsigned ext;
        ext = geo_shape[k][EXT_FIELD_W-1:0];
        return (ext == 0) ? 1 : ext;
    endfunction

    function automatic logic [STRIDE_W-1:0] stride_of(input int k);
        return geo_shape[k][GEOM_W-1:EXT_FIELD_W];
    endfunction

    function automatic void clear_walk();
        int k;
        for (k = 0; k < NUM_GEOM; k++)
            walk_index[k] = '0;
        element_total = '0;
    endfunction

    // offsets of the next element, then step the row-major walk
    function automatic offset_rec_t next_element_offsets(input logic restart_bit);
        offset_rec_t         rec;
        int unsigned         used;
        logic [63:0]         wide;
        logic [OFFSET_W-1:0] term;
        int                  k;
        bit                  carried;
        // dim_count above the dimension limit saturates
        used = (geo_dim_count > DEF_MAX_DIMS) ? DEF_MAX_DIMS : geo_dim_count;
        if (restart_bit)
            clear_walk();
        rec.src = '0;
        rec.last = 1'b1;
        for (k = 0; k < used; k++)
        begin
            // every product and the sum wrap at the offset width
            wide = 64'(walk_index[k]) * 64'(stride_of(k));
            term = wide[OFFSET_W-1:0];
            wide = 64'(term) * 64'(geo_elem_bytes);
            rec.src = rec.src + wide[OFFSET_W-1:0];
            // an index at or past its extent counts as at its end
            if (32'(walk_index[k]) + 1 < extent_of(k))
                rec.last = 1'b0;
        end
        wide = 64'(element_total) * 64'(geo_elem_bytes);
        rec.dst = wide[OFFSET_W-1:0];
        if (rec.last)
            clear_walk();
        else
        begin
            carried = 1'b0;
            for (k = used; k > 0 && !carried; k--)
            begin
                if (32'(walk_index[k-1]) + 1 < extent_of(k-1))
                begin
                    walk_index[k-1] = walk_index[k-1] + 1'b1;
                    carried = 1'b1;
                end
                else
                    walk_index[k-1] = '0;
            end
            element_total = element_total + 1'b1;
        end
        return rec;
    endfunction

    // register mirror follows every accepted config transaction
    always @(posedge clk)
    begin : cfg_mirror
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ELEM_BYTES: geo_elem_bytes = cfg_data[ELEM_BYTES_W-1:0];
                CFG_DIM_COUNT:  geo_dim_count = cfg_data[DIM_COUNT_W-1:0];
                CFG_DIM0_GEOM:  geo_shape[0] = cfg_data;
                CFG_DIM1_GEOM:  geo_shape[1] = cfg_data;
                CFG_DIM2_GEOM:  geo_shape[2] = cfg_data;
                CFG_DIM3_GEOM:  geo_shape[3] = cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request driver: predicts on each accepted transaction, then offers
    // the next pending request unless a random gap is drawn
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        bit slot_free;
        if (rst_n)
        begin
            slot_free = !in_valid || !in_stall;
            if (in_valid && !in_stall)
                expected_offsets.push_back(next_element_offsets(restart));
            if (in_valid && in_stall)
                input_stalls++;
            if (slot_free)
            begin
                if (pending_restart.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= pending_restart.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: oldest expectation against every accepted result
    // ------------------------------------------------------------------
    function automatic void report_mismatch(input string what,
                                            input logic [OFFSET_W-1:0] want,
                                            input logic [OFFSET_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, what, want, got);
    endfunction

    always @(posedge clk)
    begin : result_monitor
        offset_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_offsets.size() == 0)
                report_mismatch("unrequested result src", '0, src_offset);
            else
            begin
                want = expected_offsets.pop_front();
                if (src_offset !== want.src)
                    report_mismatch("src_offset", want.src, src_offset);
                if (dst_offset_bytes !== want.dst)
                    report_mismatch("dst_offset_bytes", want.dst, dst_offset_bytes);
                if (last_element !== want.last)
                    report_mismatch("last_element", OFFSET_W'(want.last), OFFSET_W'(last_element));
                if (want.last)
                    lasts_seen++;
            end
        end
        // a long hold-off overrides the random stall draw
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off, counted here so the sender keeps offering
    always @(posedge clk)
    begin : hold_counter
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_asked)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------

    // wait for an idle block: nothing queued, offered or outstanding
    task automatic settle();
        do
            @(posedge clk);
        while (pending_restart.size() != 0 || in_valid || expected_offsets.size() != 0);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // called at a rising edge; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GEOM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    function automatic logic [GEOM_W-1:0] shape(input logic [EXT_FIELD_W-1:0] ext,
                                               input logic [STRIDE_W-1:0] stride);
        return {stride, ext};
    endfunction

    task automatic queue_requests(input int count, input pace_t pace, input int restart_pct,
                                  input bit restart_first, input bit hold_off);
        int k;
        bit rs;
        @(negedge clk);
        case (pace)
            PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_GAPS:   begin send_gap_pct = 47; recv_stall_pct = 0;  end
            PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 47; end
            default:          begin send_gap_pct = 18; recv_stall_pct = 18; end
        endcase
        for (k = 0; k < count; k++)
        begin
            rs = (k == 0 && restart_first) || ($urandom_range(99) < restart_pct);
            pending_restart.push_back(rs);
            requests_sent++;
            if (rs)
                restarts_sent++;
        end
        if (hold_off)
            hold_asked++;
        settle();
    endtask

    function automatic logic [ELEM_BYTES_W-1:0] pick_elem_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return ELEM_BYTES_W'($urandom_range(31, 17));
        return ELEM_BYTES_W'($urandom_range(16, 1));
    endfunction

    function automatic logic [DIM_COUNT_W-1:0] pick_dim_count();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        if (r < 14)
            return DIM_COUNT_W'($urandom_range(7, DEF_MAX_DIMS + 1));
        return DIM_COUNT_W'($urandom_range(DEF_MAX_DIMS, 1));
    endfunction

    // small extents keep tensors short so wraps come often
    function automatic logic [EXT_FIELD_W-1:0] pick_extent();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 14)
            return EXT_FIELD_W'($urandom);
        return EXT_FIELD_W'($urandom_range(4, 1));
    endfunction

    function automatic logic [STRIDE_W-1:0] pick_stride();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return STRIDE_W'($urandom);
        if (r < 40)
            return '1;
        if (r < 45)
            return '0;
        return STRIDE_W'($urandom_range(64, 1));
    endfunction

    // fresh random setup; junk above each narrow field must be dropped
    task automatic random_setup();
        logic [63:0] junk;
        int          k;
        junk = {$urandom, $urandom};
        write_reg(CFG_ELEM_BYTES, {junk[GEOM_W-1:ELEM_BYTES_W], pick_elem_bytes()});
        junk = {$urandom, $urandom};
        write_reg(CFG_DIM_COUNT, {junk[GEOM_W-1:DIM_COUNT_W], pick_dim_count()});
        for (k = 0; k < NUM_GEOM; k++)
            write_reg(CFG_INDEX_W'(int'(CFG_DIM0_GEOM) + k), shape(pick_extent(), pick_stride()));
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, junk[GEOM_W-1:0]);
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int    phase;
        int    count;
        int    random_items;
        int    waited;
        logic [63:0] junk;
        pace_t pace;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setup: one dimension of extent 1, so every element is last
        queue_requests(3, PACE_BOTH, 0, 1'b0, 1'b0);

        // saturated dim_count, oversized elem_bytes, zero extent, max strides,
        // writes to undecoded indexes
        junk = {$urandom, $urandom};
        write_reg(CFG_ELEM_BYTES, {junk[GEOM_W-1:ELEM_BYTES_W], 5'd31});
        write_reg(CFG_DIM_COUNT, {junk[GEOM_W-1:DIM_COUNT_W], 3'd7});
        write_reg(CFG_DIM0_GEOM, shape(16'd0, 32'hFFFF_FFFF));
        write_reg(CFG_DIM1_GEOM, shape(16'd2, 32'd1));
        write_reg(CFG_DIM2_GEOM, shape(16'd3, 32'h8000_0000));
        write_reg(CFG_DIM3_GEOM, shape(16'd2, 32'hFFFF_FFFF));
        write_reg(CFG_SPARE_LO, junk[GEOM_W-1:0]);
        write_reg(CFG_SPARE_HI, ~junk[GEOM_W-1:0]);
        cfg_valid <= 1'b0;
        setups++;
        queue_requests(3, PACE_BOTH, 0, 1'b0, 1'b0);
        queue_requests(4, PACE_BOTH, 0, 1'b1, 1'b0);

        // scalar tensor: zero offsets, always last
        write_reg(CFG_DIM_COUNT, '0);
        cfg_valid <= 1'b0;
        queue_requests(2, PACE_BOTH, 0, 1'b0, 1'b0);

        // zero element size: all offsets collapse to zero
        write_reg(CFG_ELEM_BYTES, '0);
        write_reg(CFG_DIM_COUNT, 3'd4);
        cfg_valid <= 1'b0;
        queue_requests(2, PACE_BOTH, 0, 1'b0, 1'b0);

        // walk the fastest dimension to index 3, then shrink its extent
        // underneath it so the index sits past the end
        write_reg(CFG_ELEM_BYTES, 5'd16);
        write_reg(CFG_DIM3_GEOM, shape(16'd5, 32'd3));
        cfg_valid <= 1'b0;
        queue_requests(3, PACE_BOTH, 0, 1'b1, 1'b0);
        write_reg(CFG_DIM3_GEOM, shape(16'd2, 32'd3));
        cfg_valid <= 1'b0;
        queue_requests(3, PACE_BOTH, 0, 1'b0, 1'b0);

        // long single-dimension walk at full extent and stride, giving wide
        // scaled source offsets well above 32 bits
        write_reg(CFG_ELEM_BYTES, 5'd31);
        write_reg(CFG_DIM_COUNT, 3'd1);
        write_reg(CFG_DIM0_GEOM, shape(16'hFFFF, 32'hFFFF_FFFF));
        cfg_valid <= 1'b0;
        setups++;
        queue_requests(DEEP_WALK, PACE_FULL, 0, 1'b1, 1'b0);

        // random phases; mostly clean walks with a sprinkle of restarts
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_GOAL)
        begin
            if (phase == 0 || $urandom_range(4) != 0)
                random_setup();
            count = $urandom_range(150, 40);
            case (phase % 4)
                0:       pace = PACE_FULL;
                1:       pace = PACE_SEND_GAPS;
                2:       pace = PACE_RECV_STALLS;
                default: pace = PACE_BOTH;
            endcase
            // one phase holds the receiver off while requests pile up
            queue_requests(count, pace, 4, $urandom_range(1), phase == 1);
            random_items += count;
            phase++;
        end

        // final drain, bounded
        do
            @(posedge clk);
        while (pending_restart.size() != 0 || in_valid);
        waited = 0;
        while (expected_offsets.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (expected_offsets.size() != 0)
        begin
            fail_count += expected_offsets.size();
            $display("%0d expected results never arrived", expected_offsets.size());
        end

        $display("covered %0d element requests (%0d with restart) across %0d setups",
                 requests_sent, restarts_sent, setups);
        $display("saw %0d tensor wraps, %0d stalled request cycles, %0d failures",
                 lasts_seen, input_stalls, fail_count);
        if (fail_count == 0)
            $display("strided_tensor_gather_address regression: pass");
        else
            $display("strided_tensor_gather_address regression: fail");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", expected_offsets.size());
        $display("strided_tensor_gather_address regression: fail");
        $finish;
    end

endmodule
